// ===== sv/wpsl_pkg.sv =====
package wpsl_pkg;

    // Width of the running byte count; the count sticks at its all-ones value.
    localparam int LENGTH_WIDTH = 32;

    localparam int WORD_BYTES  = 8;
    localparam int WORD_WIDTH  = 8 * WORD_BYTES;
    localparam int OFFSET_W    = $clog2(WORD_BYTES);
    localparam int STEP_W      = $clog2(WORD_BYTES + 1);
    localparam int OUT_WIDTH   = 32;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [63:0] LEN_MAX_WIDE = {64{1'b1}} >> (64 - LENGTH_WIDTH);
    localparam logic [LENGTH_WIDTH-1:0] LEN_MAX = LEN_MAX_WIDE[LENGTH_WIDTH-1:0];
    localparam logic [OUT_WIDTH-1:0] LEN_MAX_OUT = LEN_MAX_WIDE[OUT_WIDTH-1:0];

    // One classified word as it travels from the front to the back.
    typedef struct packed {
        logic              first;
        logic              found;
        logic [STEP_W-1:0] step;
    } wpsl_item_t;

endpackage

// ===== sv/wpsl_front.sv =====
module wpsl_front (
    input  logic [wpsl_pkg::WORD_WIDTH-1:0] data_word,
    input  logic                            first_word,
    input  logic [wpsl_pkg::OFFSET_W-1:0]   byte_offset,
    output wpsl_pkg::wpsl_item_t            item
);
    import wpsl_pkg::*;

    logic [OFFSET_W-1:0]   start;
    logic [WORD_BYTES-1:0] zero_hit;
    logic [OFFSET_W-1:0]   hit_idx;
    logic                  hit_any;

    assign start = first_word ? byte_offset : '0;

    always_comb
    begin
        for (int i = 0; i < WORD_BYTES; i++)
        begin
            zero_hit[i] = (data_word[8*i +: 8] == 8'h00) && (OFFSET_W'(i) >= start);
        end
    end

    // Lowest zero byte at or above the start position.
    always_comb
    begin
        hit_idx = '0;
        hit_any = 1'b0;
        for (int i = WORD_BYTES - 1; i >= 0; i--)
        begin
            if (zero_hit[i])
            begin
                hit_idx = OFFSET_W'(i);
                hit_any = 1'b1;
            end
        end
    end

    always_comb
    begin
        item.first = first_word;
        item.found = hit_any;
        if (hit_any)
        begin
            item.step = STEP_W'(hit_idx) - STEP_W'(start);
        end
        else
        begin
            item.step = STEP_W'(WORD_BYTES) - STEP_W'(start);
        end
    end

endmodule

// ===== sv/wpsl_queue.sv =====
module wpsl_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  wpsl_pkg::wpsl_item_t push_item,
    output logic                 full,
    input  logic                 pop,
    output logic                 not_empty,
    output wpsl_pkg::wpsl_item_t pop_item
);
    import wpsl_pkg::*;

    wpsl_item_t        entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign full      = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== sv/wpsl_back.sv =====
module wpsl_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              item_valid,
    input  wpsl_pkg::wpsl_item_t              item,
    output logic                              item_pop,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [wpsl_pkg::OUT_WIDTH-1:0]    string_length,
    output logic                              length_saturated
);
    import wpsl_pkg::*;

    logic [LENGTH_WIDTH-1:0] bytes_reg;
    logic [LENGTH_WIDTH-1:0] bytes_next;
    logic                    open_reg;
    logic                    open_next;
    logic                    stuck_reg;
    logic                    stuck_next;
    logic                    out_valid_reg;
    logic                    out_valid_next;
    logic [OUT_WIDTH-1:0]    length_reg;
    logic                    sat_reg;

    logic [LENGTH_WIDTH-1:0] base;
    logic                    base_stuck;
    logic [LENGTH_WIDTH:0]   sum;
    logic [63:0]             bytes_wide;
    logic                    live;

    assign item_pop = item_valid && (!out_valid_reg || out_ready);

    // A new string restarts the count; otherwise only an open string counts.
    assign base       = item.first ? '0 : bytes_reg;
    assign base_stuck = item.first ? 1'b0 : stuck_reg;
    assign live       = item.first || open_reg;
    assign sum        = {1'b0, base} + (LENGTH_WIDTH + 1)'(item.step);

    always_comb
    begin
        bytes_next     = bytes_reg;
        stuck_next     = stuck_reg;
        open_next      = open_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (item_pop && live)
        begin
            if (base_stuck || sum[LENGTH_WIDTH])
            begin
                bytes_next = LEN_MAX;
                stuck_next = 1'b1;
            end
            else
            begin
                bytes_next = sum[LENGTH_WIDTH-1:0];
                stuck_next = 1'b0;
            end
            open_next = !item.found;
            if (item.found)
            begin
                out_valid_next = 1'b1;
            end
        end
    end

    assign bytes_wide = 64'(bytes_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bytes_reg     <= '0;
            stuck_reg     <= 1'b0;
            open_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            bytes_reg     <= bytes_next;
            stuck_reg     <= stuck_next;
            open_reg      <= open_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_pop && live && item.found)
        begin
            length_reg <= bytes_wide[OUT_WIDTH-1:0];
            sat_reg    <= stuck_next;
        end
    end

    assign out_valid        = out_valid_reg;
    assign string_length    = length_reg;
    assign length_saturated = sat_reg;

endmodule

// ===== sv/word_parallel_string_length.sv =====
// Channel   | Direction | tdata                          | tuser
// s_axis    | in        | [63:0] data_word               | [0] first_word, [3:1] byte_offset
// m_axis    | out       | [31:0] string_length           | [0] length_saturated
//
// One word is taken per cycle while the queue is not full; m_tvalid for a string's
// length rises from the back's output register once the word holding its terminator
// has left the queue, later by however long an earlier result stalls on m_tready.
// The front classifies each word in its accept cycle and writes it into a four-entry
// queue; the back applies one queued word per cycle to the count unless m_tready stalls.
// s_tready drops only when the queue is full, i.e. after m_tready stalls.
// Reset clears the queue, the count and the open-string flag.
module word_parallel_string_length (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // [63:0] data_word
    input  logic [3:0]  s_tuser,   // [0] first_word, [3:1] byte_offset
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] string_length
    output logic [0:0]  m_tuser    // [0] length_saturated
);
    import wpsl_pkg::*;

    wpsl_item_t front_item;
    wpsl_item_t queue_item;
    logic       queue_full;
    logic       queue_valid;
    logic       queue_pop;
    logic       push;

    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    wpsl_front u_front (
        .data_word   (s_tdata),
        .first_word  (s_tuser[0]),
        .byte_offset (s_tuser[3:1]),
        .item        (front_item)
    );

    wpsl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_valid),
        .pop_item  (queue_item)
    );

    wpsl_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .item_valid       (queue_valid),
        .item             (queue_item),
        .item_pop         (queue_pop),
        .out_valid        (m_tvalid),
        .out_ready        (m_tready),
        .string_length    (m_tdata),
        .length_saturated (m_tuser[0])
    );

endmodule

// ===== sv/wpsl_checker.sv =====
module wpsl_protocol_checks (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic [0:0]  m_tuser
);
    import wpsl_pkg::*;

    // A stalled result beat keeps its contents.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // A saturated length always reads as the count maximum.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] |-> m_tdata == LEN_MAX_OUT)
        else $error("saturated length is not the maximum");

    // The input side backs up only behind a stalled result.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(s_tready) |-> $past(m_tvalid && !m_tready))
        else $error("input stalled without output backpressure");

    // A result leaves only when it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        $fell(m_tvalid) |-> $past(m_tready))
        else $error("result dropped without a handshake");

endmodule

bind word_parallel_string_length wpsl_protocol_checks u_wpsl_checker (.*);
